/* sv/ddo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Types and constants for the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int PROD_W = 62;
	localparam int K_W    = 24;

	localparam logic [K_W-1:0] SPEED_K36       = 24'd12333480;
	localparam logic [19:0]    ANG_PER_M_Q16   = 20'd834430;
	localparam logic [30:0]    INV_GAIN_Q31    = 31'd1304065748;
	localparam logic [37:0]    PROD_CAP        = 38'h3F_FFFF_FFFF;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00_0000_0000_0001,
		ST_MUL  = 14'b00_0000_0000_0010,
		ST_KLO  = 14'b00_0000_0000_0100,
		ST_KHI  = 14'b00_0000_0000_1000,
		ST_RLO  = 14'b00_0000_0001_0000,
		ST_RHI  = 14'b00_0000_0010_0000,
		ST_FIX  = 14'b00_0000_0100_0000,
		ST_DIST = 14'b00_0000_1000_0000,
		ST_ANG  = 14'b00_0001_0000_0000,
		ST_GAIN = 14'b00_0010_0000_0000,
		ST_ROT  = 14'b00_0100_0000_0000,
		ST_CORD = 14'b00_1000_0000_0000,
		ST_POS  = 14'b01_0000_0000_0000,
		ST_OUT  = 14'b10_0000_0000_0000
	} state_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] start_x(input logic [1:0] id);
		return id[0] ? -32'sd13421773 : -32'sd93952410;
	endfunction

	function automatic logic signed [31:0] start_y(input logic [1:0] id);
		return id[1] ? -32'sd335544320 : 32'sd362387866;
	endfunction

	function automatic logic [31:0] start_h(input logic [1:0] id);
		return id[1] ? 32'h40000000 : 32'hC0000000;
	endfunction

endpackage

/* sv/differential_drive_odometry.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Integrates a differential-drive pose from sign-magnitude wheel speeds.
//
//  channel | signals                                            | handshake
//  --------+----------------------------------------------------+----------
//  in      | req_type time_stamp left_speed_raw right_speed_raw | valid/ready
//  out     | pose_x pose_y pose_heading                         | valid/ready
//  cfg     | cfg_wr_data (start pose select)                    | cfg_wr_en
//
// An init item loads the selected start pose. An update item runs, for each wheel,
// a multiply, a reciprocal divide and a correction, then angle and gain setup,
// one CORDIC step a cycle and one pose update.
// Reset loads the robot 0 start pose and clears the time.
// The result waits in an output register; the next item is taken meanwhile
// and its result is held back until that register is free.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
	parameter int TICKS_PER_UNIT = 10000,
	parameter int CORDIC_STEPS   = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [31:0]        time_stamp,
	input  logic [15:0]        left_speed_raw,
	input  logic [15:0]        right_speed_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pose_x,
	output logic signed [31:0] pose_y,
	output logic [31:0]        pose_heading,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_wr_data
);
	import ddo_pkg::*;

	localparam int          CW      = $clog2(TICKS_PER_UNIT + 1);
	localparam int          RSH     = 31 + CW;
	localparam logic [19:0] TDIV    = 20'(TICKS_PER_UNIT);
	localparam logic [32:0] RECIP   =
		33'((longint'(1) << RSH) / longint'(TICKS_PER_UNIT));
	localparam logic [53:0] SAT_LIM = 54'(longint'(TICKS_PER_UNIT) << 31);
	localparam int     NSTEP   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);

	state_t state_q;
	logic [1:0]         pose_sel_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0]        heading_q, last_time_q, t_q, elapsed_q;
	logic [14:0]        lmag_q, rmag_q;
	logic               lfwd_q, rfwd_q, w_q;
	logic [37:0]        a_q;
	logic [PROD_W-1:0]  prod_q;
	logic [83:0]        acc_q;
	logic [31:0]        q_q;
	logic signed [31:0] dl_q, dr_q, ds_q;
	logic               diff_neg_q;
	logic [51:0]        angp_q;
	logic [61:0]        sp_q;
	logic [31:0]        dth_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         it_q;
	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic [31:0]        out_h_q;

	logic [18:0]        k_op;
	logic [42:0]        k_prod;
	logic [46:0]        ae;
	logic [53:0]        nq;
	logic               n_sat;
	logic [31:0]        q_est;
	logic [50:0]        rmd;
	logic [30:0]        dmag31;
	logic signed [31:0] wdist;
	logic signed [32:0] sum, diff;
	logic [31:0]        dmag, smag;
	logic [51:0]        full_r, half_r;
	logic [31:0]        dth, hth, mid;
	logic [32:0]        xs_r;
	logic signed [33:0] xs, xi, yi;
	logic signed [34:0] nx, ny;
	logic               fwd;
	logic               out_load;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign pose_x       = out_x_q;
	assign pose_y       = out_y_q;
	assign pose_heading = out_h_q;

	always_comb begin
		k_op     = (state_q == ST_KLO) ? a_q[18:0] : a_q[37:19];
		k_prod   = 43'(k_op * SPEED_K36);
		ae       = 47'((w_q ? rmag_q : lmag_q) * elapsed_q);
		nq       = prod_q[PROD_W-1:8];
		n_sat    = (nq >= SAT_LIM);
		q_est    = acc_q[RSH+31:RSH];
		rmd      = nq[50:0] - 51'(q_est * TDIV);
		dmag31   = n_sat ? 31'h7FFF_FFFF : q_q[30:0];
		fwd      = w_q ? rfwd_q : lfwd_q;
		wdist    = fwd ? $signed({1'b0, dmag31}) : -$signed({1'b0, dmag31});
		sum      = 33'(dl_q) + 33'(dr_q);
		diff     = 33'(dr_q) - 33'(dl_q);
		dmag     = diff[32] ? 32'(-diff) : diff[31:0];
		smag     = ds_q[31] ? 32'(-ds_q) : ds_q;
		full_r   = angp_q + 52'h8000;
		half_r   = angp_q + 52'h10000;
		dth      = diff_neg_q ? 32'(-full_r[47:16]) : full_r[47:16];
		hth      = diff_neg_q ? 32'(-half_r[48:17]) : half_r[48:17];
		mid      = heading_q + hth;
		xs_r     = 33'((sp_q + 62'h4000_0000) >> 31);
		xs       = ds_q[31] ? -$signed({1'b0, xs_r}) : $signed({1'b0, xs_r});
		xi       = x_q >>> it_q;
		yi       = y_q >>> it_q;
		nx       = 35'(pos_x_q) + 35'(x_q);
		ny       = 35'(pos_y_q) + 35'(y_q);
		out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_sel_q <= '0;
		end else if (cfg_wr_en) begin
			pose_sel_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_x_q     <= start_x(2'd0);
			pos_y_q     <= start_y(2'd0);
			heading_q   <= start_h(2'd0);
			last_time_q <= '0;
			out_valid_q <= 1'b0;
			w_q         <= 1'b0;
			it_q        <= '0;
		end else begin
			if (out_load) begin
				out_x_q     <= pos_x_q;
				out_y_q     <= pos_y_q;
				out_h_q     <= heading_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						t_q       <= time_stamp;
						elapsed_q <= time_stamp - last_time_q;
						lmag_q    <= left_speed_raw[14:0];
						rmag_q    <= right_speed_raw[14:0];
						lfwd_q    <= left_speed_raw[15];
						rfwd_q    <= !right_speed_raw[15];
						w_q       <= 1'b0;
						if (!req_type) begin
							pos_x_q     <= start_x(pose_sel_q);
							pos_y_q     <= start_y(pose_sel_q);
							heading_q   <= start_h(pose_sel_q);
							last_time_q <= time_stamp;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					a_q     <= (ae > 47'(PROD_CAP)) ? PROD_CAP : ae[37:0];
					state_q <= ST_KLO;
				end
				ST_KLO: begin
					prod_q  <= {19'd0, k_prod};
					state_q <= ST_KHI;
				end
				ST_KHI: begin
					prod_q  <= prod_q + {k_prod, 19'd0};
					state_q <= ST_RLO;
				end
				ST_RLO: begin
					acc_q   <= {25'd0, 59'(nq[25:0] * RECIP)};
					state_q <= ST_RHI;
				end
				ST_RHI: begin
					acc_q   <= acc_q + {58'(nq[50:26] * RECIP), 26'd0};
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					q_q     <= (rmd >= 51'(TDIV)) ? q_est + 32'd1 : q_est;
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					if (!w_q) begin
						dl_q    <= wdist;
						w_q     <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						dr_q    <= wdist;
						state_q <= ST_ANG;
					end
				end
				ST_ANG: begin
					ds_q       <= 32'((sum + 33'(sum[32])) >>> 1);
					diff_neg_q <= diff[32];
					angp_q     <= 52'(dmag * ANG_PER_M_Q16);
					state_q    <= ST_GAIN;
				end
				ST_GAIN: begin
					sp_q    <= 62'(smag[30:0] * INV_GAIN_Q31);
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					dth_q <= dth;
					y_q   <= '0;
					it_q  <= '0;
					if (mid[31] ^ mid[30]) begin
						x_q <= -xs;
						z_q <= 34'($signed(mid + 32'h8000_0000));
					end else begin
						x_q <= xs;
						z_q <= 34'($signed(mid));
					end
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (!z_q[33]) begin
						x_q <= x_q - yi;
						y_q <= y_q + xi;
						z_q <= z_q - $signed({2'b00, atan_bam(it_q)});
					end else begin
						x_q <= x_q + yi;
						y_q <= y_q - xi;
						z_q <= z_q + $signed({2'b00, atan_bam(it_q)});
					end
					it_q <= it_q + 5'd1;
					if (it_q == LAST_STEP)
						state_q <= ST_POS;
				end
				ST_POS: begin
					pos_x_q <= (nx > 35'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
						(nx < -35'sh8000_0000) ? -32'sh8000_0000 : nx[31:0];
					pos_y_q <= (ny > 35'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
						(ny < -35'sh8000_0000) ? -32'sh8000_0000 : ny[31:0];
					heading_q   <= heading_q + dth_q;
					last_time_q <= t_q;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
